[hw/rtl/cla_pkg.sv]
// ----------------------------------------------------------------------------
// Console line assembler package
// Shared widths, character codes and result kinds of the line assembler.
// ----------------------------------------------------------------------------
package cla_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned DATA_W         = 7;
  localparam int unsigned LIMIT_W        = 6;
  localparam int unsigned LINE_DEPTH_DEF = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic [DATA_W-1:0] CH_BS  = 7'h08;
  localparam logic [DATA_W-1:0] CH_LF  = 7'h0A;
  localparam logic [DATA_W-1:0] CH_CR  = 7'h0D;
  localparam logic [DATA_W-1:0] CH_DEL = 7'h7F;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

endpackage

[hw/rtl/cla_if.sv]
// ----------------------------------------------------------------------------
// Console line assembler channels
// Valid/ready channels for received bytes, results and the limit register.
// ----------------------------------------------------------------------------
interface cla_rx_if;
  logic                         valid;
  logic                         ready;
  logic [cla_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cla_res_if;
  logic                         valid;
  logic                         ready;
  cla_pkg::kind_e               kind;
  logic [cla_pkg::DATA_W-1:0]   data;
  logic                         last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

interface cla_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cla_pkg::LIMIT_W-1:0]  line_limit;

  modport source (output valid, output line_limit, input ready);
  modport sink   (input valid, input line_limit, output ready);
endinterface

[hw/rtl/cla_ram.sv]
// ----------------------------------------------------------------------------
// Console line assembler RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module cla_ram #(
  parameter int unsigned WIDTH = cla_pkg::DATA_W,
  parameter int unsigned DEPTH = cla_pkg::LINE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/console_line_assembler_top.sv]
// ----------------------------------------------------------------------------
// Console line assembler
// Echoes received console bytes and gathers them into command lines.
// ----------------------------------------------------------------------------
// Usage: bytes come in on rx_i, one word per byte; only bits 6..0 are used.
// Each byte gives a burst of result words on res_o: an echo word, for CR a
// second echo word carrying LF, and when a line ends the stored characters
// one word each, then an end word whose data is the line length. The final
// word of a burst has last set. An LF right after a CR gives no word at all.
// The line limit is written on cfg_i, which is always ready; the user must
// write it only while the block is idle, as the block does not enforce this.
// The first word of a burst is registered and presented in the cycle after
// the byte is accepted. While the receiver keeps ready high, one word leaves
// per cycle. The line characters live in a one-port-read RAM that is read
// one entry ahead of the output register, and while the receiver keeps ready
// high that read pipeline sets the pace of one character per cycle.
// A new byte is accepted only once the previous burst has been handed to the
// output register; when the receiver stalls, the output register holds its
// word and the sequencer waits. Reset empties the line, clears the CR
// history and sets the limit to 32; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module console_line_assembler_top #(
  parameter int unsigned LINE_DEPTH = cla_pkg::LINE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cla_rx_if.sink     rx_i,
  cla_cfg_if.sink    cfg_i,
  cla_res_if.source  res_o
);

  localparam int unsigned DW = cla_pkg::DATA_W;
  localparam int unsigned FW = $clog2(LINE_DEPTH + 1);  // fill count width
  localparam int unsigned AW = $clog2(LINE_DEPTH);      // RAM address width

  typedef enum logic [1:0] {
    S_IDLE,
    S_ECHO_LF,
    S_CHAR,
    S_END
  } state_e;

  state_e                      state_q, state_d;
  logic [FW-1:0]               fill_q, fill_d;
  logic                        after_cr_q, after_cr_d;
  logic [FW-1:0]               len_q, len_d;
  logic [FW-1:0]               cnt_q, cnt_d;
  logic                        lf_line_q, lf_line_d;
  logic [cla_pkg::LIMIT_W-1:0] limit_q, limit_d;

  logic                        out_valid_q, out_valid_d;
  cla_pkg::kind_e              out_kind_q, out_kind_d;
  logic [DW-1:0]               out_data_q, out_data_d;
  logic                        out_last_q, out_last_d;

  logic          can_load;
  logic          rx_fire;
  logic [DW-1:0] ch;
  logic [FW-1:0] limit_eff;
  logic [FW-1:0] cnt_nx;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // The output register can take a new word when it is empty or being drained.
  assign can_load    = !out_valid_q || res_o.ready;
  assign rx_i.ready  = (state_q == S_IDLE) && can_load;
  assign rx_fire     = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;
  assign ch          = rx_i.rx_byte[DW-1:0];
  assign cnt_nx      = cnt_q + FW'(1);

  // A limit of zero behaves as one, a limit beyond the store as the store size.
  always_comb begin
    if (limit_q == '0) begin
      limit_eff = FW'(1);
    end else if (7'(limit_q) > 7'(LINE_DEPTH)) begin
      limit_eff = FW'(LINE_DEPTH);
    end else begin
      limit_eff = FW'(limit_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    after_cr_d  = after_cr_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    lf_line_d   = lf_line_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = fill_q[AW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (cfg_i.valid) begin
      limit_d = cfg_i.line_limit;
    end

    case (state_q)
      S_IDLE: begin
        if (rx_fire) begin
          // Prefetch the first line character; it is only used if a line ends.
          ram_re    = 1'b1;
          ram_raddr = '0;
          cnt_d     = '0;
          lf_line_d = 1'b0;
          if (ch == cla_pkg::CH_LF && after_cr_q) begin
            // The LF of a CR LF pair is swallowed without any word.
            after_cr_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
            out_kind_d  = cla_pkg::KIND_ECHO;
            out_data_d  = ch;
            out_last_d  = 1'b0;
            if (ch == cla_pkg::CH_BS || ch == cla_pkg::CH_DEL) begin
              out_last_d = 1'b1;
              if (fill_q != '0) begin
                fill_d = fill_q - FW'(1);
              end
            end else if (ch == cla_pkg::CH_CR || ch == cla_pkg::CH_LF) begin
              // An empty line is sent as a single LF character.
              lf_line_d = (fill_q == '0);
              len_d     = (fill_q == '0) ? FW'(1) : fill_q;
              fill_d    = '0;
              if (ch == cla_pkg::CH_CR) begin
                after_cr_d = 1'b1;
                state_d    = S_ECHO_LF;
              end else begin
                state_d = S_CHAR;
              end
            end else begin
              after_cr_d = 1'b0;
              if (fill_q < limit_eff) begin
                ram_we     = 1'b1;
                fill_d     = fill_q + FW'(1);
                out_last_d = 1'b1;
              end else begin
                // A full line drops the byte and is sent one character short.
                len_d   = fill_q - FW'(1);
                fill_d  = '0;
                state_d = (fill_q == FW'(1)) ? S_END : S_CHAR;
              end
            end
          end
        end
      end
      S_ECHO_LF: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_kind_d  = cla_pkg::KIND_ECHO;
          out_data_d  = cla_pkg::CH_LF;
          out_last_d  = 1'b0;
          state_d     = S_CHAR;
        end
      end
      S_CHAR: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_kind_d  = cla_pkg::KIND_CHAR;
          out_data_d  = lf_line_q ? cla_pkg::CH_LF : ram_rdata;
          out_last_d  = 1'b0;
          cnt_d       = cnt_nx;
          if (cnt_nx == len_q) begin
            state_d = S_END;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cnt_nx[AW-1:0];
          end
        end
      end
      S_END: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_kind_d  = cla_pkg::KIND_END;
          out_data_d  = DW'(len_q);
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      after_cr_q  <= 1'b0;
      len_q       <= '0;
      cnt_q       <= '0;
      lf_line_q   <= 1'b0;
      limit_q     <= cla_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
      out_kind_q  <= cla_pkg::KIND_ECHO;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      after_cr_q  <= after_cr_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      lf_line_q   <= lf_line_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_data_q  <= out_data_d;
      out_last_q  <= out_last_d;
    end
  end

  cla_ram #(
    .WIDTH (DW),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ch),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_o.valid = out_valid_q;
  assign res_o.kind  = out_kind_q;
  assign res_o.data  = out_data_q;
  assign res_o.last  = out_last_q;

  // The fill count never runs past the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(LINE_DEPTH))
    else $error("fill count beyond line store");

  // While streaming characters the index stays below the line length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHAR) |-> (cnt_q < len_q))
    else $error("character index past line length");

  // An end word always closes its burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == cla_pkg::KIND_END) |-> (out_last_q && state_q == S_IDLE))
    else $error("end word not last of burst");

  // A byte that is stored ends its burst and leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (state_q == S_IDLE && out_valid_q && out_last_q))
    else $error("stored byte did not end its burst");

endmodule
